>>> sv/pct_pkg.sv
// Shared types and constants for the periodic callback table.
package pct_pkg;

  localparam int SLOTS_DEFAULT = 10;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_FIRED = 2'd2,
    ST_IDLE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] handler;
    logic [15:0] period;
    logic [15:0] remaining;
    logic [31:0] argument;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic clr;
  } chain_ctl_t;

endpackage

>>> sv/pct_cell.sv
// One table slot: holds an entry and takes its neighbor's entry on each shift.
module pct_cell
  import pct_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  chain_ctl_t ctl,
  input  entry_t     d_in,
  output entry_t     q
);

  entry_t entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      entry_r <= '0;
    end else if (ctl.shift) begin
      entry_r <= d_in;
    end
  end

  assign q = entry_r;

endmodule

>>> sv/pct_ctrl.sv
// Command sequencer: rotates the slot chain once per add, remove or enabled tick and forms results.
module pct_ctrl
  import pct_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  entry_t      head,
  input  entry_t      nxt,
  output entry_t      tail,
  output chain_ctl_t  ctl
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FINISH} state_t;

  state_t             state_r;
  cmd_t               cmd_r;
  logic [31:0]        hid_r;
  logic [15:0]        per_r;
  logic [31:0]        arg_r;
  logic [IDX_W-1:0]   idx_r;
  logic               found_r;
  logic               shifted_r;
  logic               enable_r;
  logic               pend_valid_r;
  logic [31:0]        pend_handler_r;
  logic [31:0]        pend_arg_r;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [31:0]        out_handler_r;
  logic [31:0]        out_arg_r;
  logic               out_last_r;

  logic    accept;
  cmd_t    in_cmd;
  logic    out_free;
  logic    head_fire;
  logic    flush_pend;
  logic    step_en;
  logic    last_step;
  logic    rm_match;
  logic    add_hit;
  logic    out_load;
  status_t fin_status;
  logic    fin_fired;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_cmd    = cmd_t'(in_tuser);

  assign out_free   = !out_valid_r || out_tready;
  assign head_fire  = (cmd_r == CMD_TICK) && (head.handler != '0) && (head.remaining == '0);
  assign flush_pend = head_fire && pend_valid_r;
  assign step_en    = (state_r == S_WALK) && (!flush_pend || out_free);
  assign last_step  = (idx_r == IDX_W'(SLOTS - 1));
  assign rm_match   = !shifted_r && (hid_r != '0) && (head.handler == hid_r) &&
                      (head.argument == arg_r);
  assign add_hit    = !found_r && (head.handler == '0);
  assign out_load   = (step_en && flush_pend) ||
                      ((state_r == S_FINISH) && out_free);

  assign ctl.shift = step_en;
  assign ctl.clr   = accept && (in_cmd == CMD_CLEAR);

  always_comb begin
    tail = head;
    unique case (cmd_r)
      CMD_TICK: begin
        if (head.handler != '0) begin
          if (head.remaining == '0) begin
            tail.remaining = head.period;
          end else begin
            tail.remaining = head.remaining - 16'd1;
          end
        end
      end
      CMD_ADD: begin
        if (add_hit && (hid_r != '0)) begin
          tail.handler   = hid_r;
          tail.period    = per_r;
          tail.remaining = '0;
          tail.argument  = arg_r;
        end
      end
      CMD_REMOVE: begin
        if (shifted_r || rm_match) begin
          tail = last_step ? '0 : nxt;
        end
      end
      default: tail = head;
    endcase
  end

  always_comb begin
    fin_fired = (cmd_r == CMD_TICK) && pend_valid_r;
    unique case (cmd_r)
      CMD_TICK: fin_status = pend_valid_r ? ST_FIRED : ST_IDLE;
      CMD_ADD:  fin_status = found_r ? ST_DONE : ST_FULL;
      default:  fin_status = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      enable_r     <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      shifted_r    <= 1'b0;
      idx_r        <= '0;
      cmd_r        <= CMD_TICK;
    end else begin
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r        <= in_cmd;
            hid_r        <= in_tdata[31:0];
            per_r        <= in_tdata[47:32];
            arg_r        <= in_tdata[79:48];
            idx_r        <= '0;
            found_r      <= 1'b0;
            shifted_r    <= 1'b0;
            pend_valid_r <= 1'b0;
            if ((in_cmd == CMD_CLEAR) || ((in_cmd == CMD_TICK) && !enable_r)) begin
              state_r <= S_FINISH;
            end else begin
              state_r <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (step_en) begin
            idx_r <= idx_r + IDX_W'(1);
            if ((cmd_r == CMD_ADD) && add_hit) begin
              found_r <= 1'b1;
            end
            if ((cmd_r == CMD_REMOVE) && rm_match) begin
              shifted_r <= 1'b1;
            end
            if (head_fire) begin
              if (pend_valid_r) begin
                out_status_r  <= ST_FIRED;
                out_handler_r <= pend_handler_r;
                out_arg_r     <= pend_arg_r;
                out_last_r    <= 1'b0;
              end
              pend_valid_r   <= 1'b1;
              pend_handler_r <= head.handler;
              pend_arg_r     <= head.argument;
            end
            if (last_step) begin
              state_r <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_status_r  <= fin_status;
            out_handler_r <= fin_fired ? pend_handler_r : '0;
            out_arg_r     <= fin_fired ? pend_arg_r : '0;
            out_last_r    <= 1'b1;
            pend_valid_r  <= 1'b0;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_arg_r, out_handler_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

>>> sv/periodic_callback_table_top.sv
// Top level of the periodic callback table: slot chain plus command sequencer.
//
// Commands enter on the in_ stream (command in in_tuser, operands in in_tdata).
// Results leave on the out_ stream: status in out_tuser, fired handler and
// argument in out_tdata, out_tlast on the final result of each command.
// cfg_we/cfg_wdata write the scheduler enable bit.
// Every add, remove and enabled tick rotates the slot chain once through the
// sequencer, one slot per cycle while no stalled result pauses the rotation;
// the final result is registered in S_FINISH, where the sequencer returns to
// idle and is then ready for the next command.
// Clear and disabled ticks skip the rotation; clear empties all slots at once.
// A tick that fires several handlers emits one transaction per fired handler,
// all but the last during the rotation; the last one carries out_tlast.
// Reset empties the table and clears the enable bit.
// When the receiver stalls, hold the result and pause the rotation as soon
// as a further fired handler needs the output register.
module periodic_callback_table_top
  import pct_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // handler_id[31:0], period[47:32], argument[79:48]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // fired_handler[31:0], fired_argument[63:32]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  entry_t     cell_q [SLOTS];
  entry_t     tail;
  entry_t     nxt;
  chain_ctl_t ctl;

  generate
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      if (i == SLOTS - 1) begin : g_last
        pct_cell u_cell (
          .clk  (clk),
          .rst_n(rst_n),
          .ctl  (ctl),
          .d_in (tail),
          .q    (cell_q[i])
        );
      end else begin : g_mid
        pct_cell u_cell (
          .clk  (clk),
          .rst_n(rst_n),
          .ctl  (ctl),
          .d_in (cell_q[i+1]),
          .q    (cell_q[i])
        );
      end
    end
    if (SLOTS > 1) begin : g_nxt
      assign nxt = cell_q[1];
    end else begin : g_nxt_none
      assign nxt = '0;
    end
  endgenerate

  pct_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (cell_q[0]),
    .nxt       (nxt),
    .tail      (tail),
    .ctl       (ctl)
  );

endmodule
